FILE: rtl/core/dcqs_pkg.sv
// ---------------------------------------------------------------------------
// Display command queue sequencer package
// Shared opcode and status codes, record layout and default sizes.
// ---------------------------------------------------------------------------
package dcqs_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int OPCODE_W   = 3;
    localparam int ARGUMENT_W = 16;
    localparam int ELAPSED_W  = 16;
    localparam int COUNTER_W  = 17;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int RECORD_W   = OPCODE_W + ARGUMENT_W;

    typedef enum logic [OPCODE_W-1:0] {
        OP_BUSY_HIGH  = 3'd0,
        OP_BUSY_LOW   = 3'd1,
        OP_WAIT       = 3'd2,
        OP_CMD_BYTE   = 3'd3,
        OP_DATA_BYTE  = 3'd4,
        OP_RESET_HIGH = 3'd5,
        OP_RESET_LOW  = 3'd6
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_EMPTY       = 3'd0,
        ST_WAITING     = 3'd1,
        ST_WAIT_DONE   = 3'd2,
        ST_ACTION_DONE = 3'd3,
        ST_ACCEPTED    = 3'd4,
        ST_REJECTED    = 3'd5
    } t_status;

    typedef enum logic {
        KIND_ENQUEUE = 1'b0,
        KIND_POLL    = 1'b1
    } t_kind;

endpackage

FILE: rtl/core/dcqs_ram.sv
// ---------------------------------------------------------------------------
// Display command queue sequencer record RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module dcqs_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/display_command_queue_sequencer.sv
// ---------------------------------------------------------------------------
// Display command queue sequencer
// Ring of panel command records; each poll word acts on at most one record.
// ---------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): an enqueue word appends one record
// (opcode, argument) or is rejected when the ring is full; a poll word acts on
// the oldest record with the elapsed milliseconds and the busy pin level.
// Output channel (o_out_valid / i_out_ready): exactly one result word per
// input word, in order, with status, serial byte action, reset line action
// and the free record count after the step.
// An accepted word waits in the input register; its result is registered
// once the output register is free. Throughput: one word per cycle while
// results are taken, set by the single pass from the input register through
// the record RAM read and the elapsed add/compare to the result register.
// The next head record is read from the RAM while the word is accepted; a
// record written in the same cycle to that slot is forwarded.
// Reset: ring empty, elapsed counter cleared, both registers empty. RAM
// contents stay undefined; only written records are ever used.
// Receiver stall: the result word holds; the input register takes one more
// word, then o_in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
module display_command_queue_sequencer
    import dcqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [OPCODE_W-1:0]              i_opcode,
    input  logic [ARGUMENT_W-1:0]            i_argument,
    input  logic [ELAPSED_W-1:0]             i_elapsed_ms,
    input  logic                             i_busy_level,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [STATUS_W-1:0]              o_status,
    output logic [BYTE_W-1:0]                o_serial_byte,
    output logic                             o_serial_send,
    output logic                             o_data_level,
    output logic                             o_reset_level,
    output logic                             o_reset_change,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_free_slots
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] next_index(input logic [AW-1:0] idx);
        logic [AW-1:0] nxt;
        if (idx == AW'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + AW'(1);
        end
        return nxt;
    endfunction

    // input register
    logic                  r_in_valid;
    logic                  r_kind;
    logic [OPCODE_W-1:0]   r_opcode;
    logic [ARGUMENT_W-1:0] r_argument;
    logic [ELAPSED_W-1:0]  r_elapsed_ms;
    logic                  r_busy_level;

    // ring state
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;
    logic [COUNTER_W-1:0] r_elapsed, n_elapsed;

    // forwarded record
    logic                r_byp;
    logic [RECORD_W-1:0] r_byp_data;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [BYTE_W-1:0]   r_serial_byte, n_serial_byte;
    logic                r_serial_send, n_serial_send;
    logic                r_data_level, n_data_level;
    logic                r_reset_level, n_reset_level;
    logic                r_reset_change, n_reset_change;
    logic [CW-1:0]       r_free, n_free;

    logic                  in_fire;
    logic                  advance;
    logic                  wr_en;
    logic [RECORD_W-1:0]   wr_data;
    logic [RECORD_W-1:0]   ram_q;
    logic [RECORD_W-1:0]   rec;
    logic [OPCODE_W-1:0]   rec_op;
    logic [ARGUMENT_W-1:0] rec_arg;
    logic [COUNTER_W-1:0]  sum;
    logic                  matched;
    logic                  retire;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_fire    = i_in_valid && o_in_ready;

    assign wr_data = {r_opcode, r_argument};
    assign rec     = r_byp ? r_byp_data : ram_q;
    assign rec_op  = rec[RECORD_W-1 -: OPCODE_W];
    assign rec_arg = rec[ARGUMENT_W-1:0];
    assign sum     = r_elapsed + COUNTER_W'(r_elapsed_ms);
    assign matched = ((rec_op == OP_BUSY_HIGH) && r_busy_level)
                  || ((rec_op == OP_BUSY_LOW) && !r_busy_level);

    dcqs_ram #(
        .WIDTH(RECORD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_tail),
        .i_wr_data(wr_data),
        .i_rd_en  (in_fire),
        .i_rd_addr(n_head),
        .o_rd_data(ram_q)
    );

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_elapsed      = r_elapsed;
        wr_en          = 1'b0;
        retire         = 1'b0;
        n_status       = ST_EMPTY;
        n_serial_byte  = '0;
        n_serial_send  = 1'b0;
        n_data_level   = 1'b0;
        n_reset_level  = 1'b0;
        n_reset_change = 1'b0;
        if (advance) begin
            if (r_kind == KIND_ENQUEUE) begin
                if (r_count == CW'(QUEUE_DEPTH)) begin
                    n_status = ST_REJECTED;
                end else begin
                    wr_en    = 1'b1;
                    n_tail   = next_index(r_tail);
                    n_count  = r_count + CW'(1);
                    n_status = ST_ACCEPTED;
                end
            end else if (r_count != '0) begin
                case (rec_op)
                    OP_BUSY_HIGH, OP_BUSY_LOW, OP_WAIT: begin
                        if (matched || (sum >= COUNTER_W'(rec_arg))) begin
                            retire   = 1'b1;
                            n_status = ST_WAIT_DONE;
                        end else begin
                            n_elapsed = sum;
                            n_status  = ST_WAITING;
                        end
                    end
                    OP_CMD_BYTE, OP_DATA_BYTE: begin
                        retire        = 1'b1;
                        n_status      = ST_ACTION_DONE;
                        n_serial_byte = rec_arg[BYTE_W-1:0];
                        n_serial_send = 1'b1;
                        n_data_level  = (rec_op == OP_DATA_BYTE);
                    end
                    OP_RESET_HIGH, OP_RESET_LOW: begin
                        retire         = 1'b1;
                        n_status       = ST_ACTION_DONE;
                        n_reset_level  = (rec_op == OP_RESET_HIGH);
                        n_reset_change = 1'b1;
                    end
                    default: begin
                        retire   = 1'b1;
                        n_status = ST_ACTION_DONE;
                    end
                endcase
                if (retire) begin
                    n_head    = next_index(r_head);
                    n_count   = r_count - CW'(1);
                    n_elapsed = '0;
                end
            end
        end
        n_free = CW'(QUEUE_DEPTH) - n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_elapsed   <= '0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_elapsed <= n_elapsed;
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind       <= i_kind;
            r_opcode     <= i_opcode;
            r_argument   <= i_argument;
            r_elapsed_ms <= i_elapsed_ms;
            r_busy_level <= i_busy_level;
            r_byp        <= wr_en && (r_tail == n_head);
            r_byp_data   <= wr_data;
        end
        if (advance) begin
            r_status       <= n_status;
            r_serial_byte  <= n_serial_byte;
            r_serial_send  <= n_serial_send;
            r_data_level   <= n_data_level;
            r_reset_level  <= n_reset_level;
            r_reset_change <= n_reset_change;
            r_free         <= n_free;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_serial_byte  = r_serial_byte;
    assign o_serial_send  = r_serial_send;
    assign o_data_level   = r_data_level;
    assign o_reset_level  = r_reset_level;
    assign o_reset_change = r_reset_change;
    assign o_free_slots   = r_free;

endmodule

FILE: rtl/core/dcqs_checker.sv
// ---------------------------------------------------------------------------
// Display command queue sequencer checker
// Port-level properties of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module dcqs_checker
    import dcqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [STATUS_W-1:0]              o_status,
    input logic                             o_serial_send,
    input logic                             o_reset_change,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0] o_free_slots
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold_stalled_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_free_slots))
        else $error("stalled result word changed");

    a_action_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_serial_send || o_reset_change) |->
            (o_status == ST_ACTION_DONE) && !(o_serial_send && o_reset_change))
        else $error("panel action without action done status");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_REJECTED) |-> (o_free_slots == '0))
        else $error("enqueue rejected with free records");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == ST_ACCEPTED) || (o_status == ST_WAITING)) |->
            (o_free_slots < CW'(QUEUE_DEPTH)))
        else $error("free record count out of range");

endmodule

bind display_command_queue_sequencer dcqs_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
) u_dcqs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_serial_send (o_serial_send),
    .o_reset_change(o_reset_change),
    .o_free_slots  (o_free_slots)
);
